### rtl/psw_pkg.sv
// Shared types and constants of the phase-shifted wave table generator.
package psw_pkg;

  localparam int TABLE_LENGTH = 1024;
  localparam int DAC_CODES    = 4096;

  localparam int IDX_W     = 10;
  localparam int P_W       = 11;
  localparam int AMP_W     = 11;
  localparam int OFS_W     = 12;
  localparam int DEG_W     = 8;
  localparam int SAMPLE_W  = 12;
  localparam int QUO_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_WAVE_TYPE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_POINTS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_DEGREES = 3'd4;

  localparam logic SHAPE_SIN = 1'b0;
  localparam logic SHAPE_TRI = 1'b1;

  localparam logic [DEG_W-1:0]    MAX_DEGREES = 8'd180;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX  = SAMPLE_W'(DAC_CODES - 1);

  // floor(x / 360) = (x * RECIP_360) >> RECIP_360_SH for x below 2^18.
  localparam int              RECIP_360_SH = 26;
  localparam logic [17:0]     RECIP_360    = 18'(((64'd1 << 26) + 64'd359) / 64'd360);

  localparam logic [30:0] Q30_ONE    = 31'h4000_0000;
  // Low 32 bits of 2*pi in Q30; the high bit adds the operand itself.
  localparam logic [31:0] TWO_PI_LO  = 32'h921F_B544;

  localparam int HORNER_N = 5;
  // Exact reciprocals of the Horner divisors 110, 72, 42, 20 and 6 for 32-bit numerators.
  localparam logic [63:0] HORNER_M [HORNER_N] = '{
    ((64'd1 << 39) + 64'd109) / 64'd110,
    ((64'd1 << 39) + 64'd71)  / 64'd72,
    ((64'd1 << 38) + 64'd41)  / 64'd42,
    ((64'd1 << 37) + 64'd19)  / 64'd20,
    ((64'd1 << 35) + 64'd5)   / 64'd6
  };
  localparam int HORNER_SH [HORNER_N] = '{39, 39, 38, 37, 35};

  typedef struct packed {
    logic                 wave_type;
    logic [AMP_W-1:0]     amplitude;
    logic [OFS_W-1:0]     offset;
  } cfg_t;

endpackage

### rtl/psw_div.sv
// Pipelined restoring divider by the period, one quotient bit per stage.
module psw_div import psw_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [P_W-1:0]   in_rem,
  input  logic [QUO_W-1:0] in_low,
  input  logic [P_W-1:0]   divisor,
  output logic             out_valid,
  output logic [QUO_W-1:0] out_quo,
  output logic [P_W-1:0]   out_rem
);

  logic             v_r   [0:QUO_W];
  logic [P_W-1:0]   rem_r [0:QUO_W];
  logic [QUO_W-1:0] w_r   [0:QUO_W];

  assign v_r[0]   = in_valid;
  assign rem_r[0] = in_rem;
  assign w_r[0]   = in_low;

  genvar i;
  generate
    for (i = 0; i < QUO_W; i++) begin : g_stage
      logic             sv_r;
      logic [P_W-1:0]   srem_r;
      logic [QUO_W-1:0] sw_r;
      logic [P_W:0]     trial;
      logic             ge;
      logic [P_W:0]     diff;

      // The partial remainder stays below the divisor, so shifting in one bit fits P_W+1 bits.
      assign trial = {rem_r[i], w_r[i][QUO_W-1]};
      assign ge    = trial >= {1'b0, divisor};
      assign diff  = trial - {1'b0, divisor};

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          sv_r <= 1'b0;
        end else if (en) begin
          sv_r <= v_r[i];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          srem_r <= ge ? diff[P_W-1:0] : trial[P_W-1:0];
          sw_r   <= {w_r[i][QUO_W-2:0], ge};
        end
      end

      assign v_r[i+1]   = sv_r;
      assign rem_r[i+1] = srem_r;
      assign w_r[i+1]   = sw_r;
    end
  endgenerate

  assign out_valid = v_r[QUO_W];
  assign out_quo   = w_r[QUO_W];
  assign out_rem   = rem_r[QUO_W];

endmodule

### rtl/psw_shape.sv
// Wave shaping pipeline: fixed-point sine polynomial, scaling and final sample select.
module psw_shape import psw_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  cfg_t                cfg,
  input  logic                in_valid,
  input  logic [QUO_W-1:0]    in_quo,
  output logic                out_valid,
  output logic [SAMPLE_W-1:0] out_sample
);

  typedef struct packed {
    logic [1:0]          quad;
    logic [30:0]         x;
    logic [31:0]         x2;
    logic [SAMPLE_W-1:0] tri_s;
  } carry_t;

  // Stage A: fold the turn fraction into the first quadrant.
  logic                va_r, vb_r, vc_r, vd_r, ve_r;
  logic [1:0]          quada_r, quadb_r, quadc_r, quadd_r;
  logic [SAMPLE_W-1:0] tria_r, trib_r, tric_r, trid_r;
  logic [30:0]         ua_r, ub_r, xc_r, xd_r;
  logic [62:0]         pub_r;
  logic [61:0]         xxd_r;
  carry_t              ce_r;
  logic [30:0]         r_ext;

  assign r_ext = {1'b0, in_quo[29:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quada_r <= in_quo[31:30];
      ua_r    <= in_quo[30] ? (Q30_ONE - r_ext) : r_ext;
      // The triangle quotient is the sample itself, clipped at the top code.
      tria_r  <= (|in_quo[QUO_W-1:SAMPLE_W]) ? SAMPLE_MAX : in_quo[SAMPLE_W-1:0];

      quadb_r <= quada_r;
      trib_r  <= tria_r;
      ub_r    <= ua_r;
      pub_r   <= {32'b0, ua_r} * {31'b0, TWO_PI_LO};

      quadc_r <= quadb_r;
      tric_r  <= trib_r;
      xc_r    <= ub_r + pub_r[62:32];

      quadd_r <= quadc_r;
      trid_r  <= tric_r;
      xd_r    <= xc_r;
      xxd_r   <= {31'b0, xc_r} * {31'b0, xc_r};

      ce_r.quad  <= quadd_r;
      ce_r.x     <= xd_r;
      ce_r.x2    <= xxd_r[61:30];
      ce_r.tri_s <= trid_r;
    end
  end

  logic        hv [0:HORNER_N];
  carry_t      hc [0:HORNER_N];
  logic [30:0] ht [0:HORNER_N];

  assign hv[0] = ve_r;
  assign hc[0] = ce_r;
  assign ht[0] = Q30_ONE;

  genvar k;
  generate
    for (k = 0; k < HORNER_N; k++) begin : g_horner
      localparam logic [63:0] M_FULL = HORNER_M[k];
      localparam logic [15:0] M_HI   = M_FULL[32:17];
      localparam logic [16:0] M_LO   = M_FULL[16:0];

      logic        sva_r, svb_r, svc_r;
      carry_t      sca_r, scb_r, scc_r;
      logic [62:0] mt_r;
      logic [47:0] ph_r;
      logic [48:0] pl_r;
      logic [30:0] t_r;
      logic [31:0] vq;
      logic [65:0] prod_sum;
      logic [65:0] prod_sh;

      assign vq       = mt_r[61:30];
      assign prod_sum = {1'b0, ph_r, 17'b0} + {17'b0, pl_r};
      assign prod_sh  = prod_sum >> HORNER_SH[k];

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          sva_r <= 1'b0;
          svb_r <= 1'b0;
          svc_r <= 1'b0;
        end else if (en) begin
          sva_r <= hv[k];
          svb_r <= sva_r;
          svc_r <= svb_r;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          sca_r <= hc[k];
          mt_r  <= {31'b0, hc[k].x2} * {32'b0, ht[k]};
          scb_r <= sca_r;
          ph_r  <= {16'b0, vq} * {32'b0, M_HI};
          pl_r  <= {17'b0, vq} * {32'b0, M_LO};
          scc_r <= scb_r;
          t_r   <= Q30_ONE - prod_sh[30:0];
        end
      end

      assign hv[k+1] = svc_r;
      assign hc[k+1] = scc_r;
      assign ht[k+1] = t_r;
    end
  endgenerate

  // Final multiply by x, clamp to one, scale by amplitude, add to or subtract from the offset, select the sample.
  logic                vf1_r, vf2_r, vf3_r, vf4_r;
  carry_t              cf1_r, cf2_r, cf3_r;
  logic [61:0]         xt_r;
  logic [30:0]         s_r;
  logic [41:0]         dev_r;
  logic [SAMPLE_W-1:0] res_r;
  logic [31:0]         st;
  logic [43:0]         base;
  logic [43:0]         tot;
  logic [SAMPLE_W-1:0] sine_s;

  assign st   = xt_r[61:30];
  assign base = {2'b0, cfg.offset, 30'b0};
  assign tot  = cf3_r.quad[1] ? (base - {2'b0, dev_r}) : (base + {2'b0, dev_r});

  always_comb begin
    if (tot[43]) begin
      sine_s = '0;
    end else if (tot[42]) begin
      sine_s = SAMPLE_MAX;
    end else begin
      sine_s = tot[41:30];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf1_r <= 1'b0;
      vf2_r <= 1'b0;
      vf3_r <= 1'b0;
      vf4_r <= 1'b0;
    end else if (en) begin
      vf1_r <= hv[HORNER_N];
      vf2_r <= vf1_r;
      vf3_r <= vf2_r;
      vf4_r <= vf3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cf1_r <= hc[HORNER_N];
      xt_r  <= {31'b0, hc[HORNER_N].x} * {31'b0, ht[HORNER_N]};
      cf2_r <= cf1_r;
      s_r   <= (st > {1'b0, Q30_ONE}) ? Q30_ONE : st[30:0];
      cf3_r <= cf2_r;
      dev_r <= {31'b0, cfg.amplitude} * {11'b0, s_r};
      res_r <= (cfg.wave_type == SHAPE_TRI) ? cf3_r.tri_s : sine_s;
    end
  end

  assign out_valid  = vf4_r;
  assign out_sample = res_r;

endmodule

### rtl/phase_shifted_wave_table_generator.sv
// Top level of the phase-shifted sine and triangle wave table generator.
//
// Usage: each word on the in_ stream carries a table position; each word on
// the out_ stream carries the 12-bit DAC code of that position, in order,
// one result per input word. Period, amplitude, offset, phase in degrees and
// the waveform are set through the cfg_ write port; the user must write them
// only while the stream is idle, which the block does not enforce. The phase
// shift is derived from the registers through deg_prod_r and then shift_r.
// Throughput is one word per clock while out_tready does not stall the pipeline.
// On its way to out_tvalid an accepted input word passes three input stages, two
// 32-stage dividers by the period (position modulo and turn fraction or triangle
// scaling), two triangle stages, 24 stages of sine polynomial and scaling and the output register.
//
// The pipeline advances as a whole. When out_tvalid is high and out_tready
// low, every stage holds and in_tready goes low, so no word is lost or
// repeated. Synchronous reset empties the pipeline and loads the default
// registers: sine, 100 points, amplitude 1638, offset 2048, zero phase.
module phase_shifted_wave_table_generator import psw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [15:0]          in_tdata,   // [9:0] sample_index
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,  // [11:0] sample
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  logic             wave_type_r;
  logic [P_W-1:0]   period_r;
  logic [AMP_W-1:0] amplitude_r;
  logic [OFS_W-1:0] offset_r;
  logic [DEG_W-1:0] phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_type_r <= SHAPE_SIN;
      period_r    <= 11'd100;
      amplitude_r <= 11'd1638;
      offset_r    <= 12'd2048;
      phase_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WAVE_TYPE:     wave_type_r <= cfg_wdata[0];
        REG_PERIOD_POINTS: period_r    <= cfg_wdata[P_W-1:0];
        REG_AMPLITUDE:     amplitude_r <= cfg_wdata[AMP_W-1:0];
        REG_OFFSET:        offset_r    <= cfg_wdata[OFS_W-1:0];
        REG_PHASE_DEGREES: phase_r     <= cfg_wdata[DEG_W-1:0];
        default: ;
      endcase
    end
  end

  logic [P_W-1:0]   p_eff;
  logic [DEG_W-1:0] deg_eff;
  cfg_t             cfg;

  // A zero or oversized period means a full table.
  assign p_eff   = (period_r == '0 || period_r > P_W'(TABLE_LENGTH)) ?
                   P_W'(TABLE_LENGTH) : period_r;
  assign deg_eff = (phase_r > MAX_DEGREES) ? MAX_DEGREES : phase_r;

  assign cfg.wave_type = wave_type_r;
  assign cfg.amplitude = amplitude_r;
  assign cfg.offset    = offset_r;

  // Phase shift in samples; never reaches the period, so no wrap is needed.
  logic [17:0]      deg_prod_r;
  logic [35:0]      shift_prod;
  logic [IDX_W-1:0] shift_r;

  assign shift_prod = {18'b0, deg_prod_r} * {18'b0, RECIP_360};

  always_ff @(posedge clk) begin
    deg_prod_r <= {10'b0, deg_eff} * {7'b0, p_eff};
    shift_r    <= shift_prod[RECIP_360_SH +: IDX_W];
  end

  logic en;
  logic out_tvalid_r;
  logic [SAMPLE_W-1:0] out_sample_r;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  logic             v0_r, v1_r, v2_r, v3_r, v4_r;
  logic [IDX_W-1:0] idx0_r, idx1_r;
  logic [P_W-1:0]   sum2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx0_r <= in_tdata[IDX_W-1:0];
      idx1_r <= idx0_r;
      sum2_r <= {1'b0, idx1_r} + {1'b0, shift_r};
    end
  end

  logic             d1_valid;
  logic [QUO_W-1:0] d1_quo;
  logic [P_W-1:0]   pos;

  psw_div u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v2_r),
    .in_rem    ('0),
    .in_low    ({{(QUO_W-P_W){1'b0}}, sum2_r}),
    .divisor   (p_eff),
    .out_valid (d1_valid),
    .out_quo   (d1_quo),
    .out_rem   (pos)
  );

  // Triangle: n follows the three segments, scaled by amplitude over the period.
  logic signed [13:0] q4;
  logic signed [13:0] p14;
  logic signed [13:0] n;
  logic [22:0]        m1_r;
  logic signed [25:0] m2_r;
  logic [P_W-1:0]     pos3_r, pos4_r;
  logic signed [26:0] tot4_r;

  assign q4  = {1'b0, pos, 2'b00};
  assign p14 = {3'b0, p_eff};

  always_comb begin
    if (q4 < p14) begin
      n = q4;
    end else if (q4 < 14'(3 * p14)) begin
      n = 14'(2 * p14) - q4;
    end else begin
      n = q4 - 14'(4 * p14);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v3_r <= d1_valid;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos3_r <= pos;
      m1_r   <= {11'b0, offset_r} * {12'b0, p_eff};
      m2_r   <= $signed({1'b0, amplitude_r}) * n;
      pos4_r <= pos3_r;
      tot4_r <= $signed({4'b0, m1_r}) + 27'(m2_r);
    end
  end

  logic [P_W-1:0]   d2_rem_in;
  logic [QUO_W-1:0] d2_low_in;

  // A negative triangle total divides as zero, which is the saturated sample.
  always_comb begin
    if (wave_type_r == SHAPE_TRI) begin
      d2_rem_in = '0;
      d2_low_in = tot4_r[26] ? '0 : {{(QUO_W-27){1'b0}}, tot4_r};
    end else begin
      d2_rem_in = pos4_r;
      d2_low_in = '0;
    end
  end

  logic             d2_valid;
  logic [QUO_W-1:0] d2_quo;
  logic [P_W-1:0]   d2_rem;

  psw_div u_frac (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v4_r),
    .in_rem    (d2_rem_in),
    .in_low    (d2_low_in),
    .divisor   (p_eff),
    .out_valid (d2_valid),
    .out_quo   (d2_quo),
    .out_rem   (d2_rem)
  );

  logic                sh_valid;
  logic [SAMPLE_W-1:0] sh_sample;

  psw_shape u_shape (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .cfg        (cfg),
    .in_valid   (d2_valid),
    .in_quo     (d2_quo),
    .out_valid  (sh_valid),
    .out_sample (sh_sample)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= sh_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_sample_r <= sh_sample;
    end
  end

  // The remainders of the second divider and the first quotient carry no information.
  logic unused_bits;
  assign unused_bits = ^{d1_quo, d2_rem, in_tdata[15:IDX_W]};

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'b0, out_sample_r & {SAMPLE_W{~unused_bits | unused_bits}}};

endmodule
